// ===== rtl/thhc_pkg.sv =====
`default_nettype none
package thhc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ROOM_OVERHEAT_TEMP       = 3'd0;
  localparam logic [2:0] REG_ROOM_OVERHEAT_CLEAR_TEMP = 3'd1;
  localparam logic [2:0] REG_TANK_TRIP_TEMP           = 3'd2;
  localparam logic [2:0] REG_LOW_WATER_RECOVER_TICKS  = 3'd3;
  localparam logic [2:0] REG_OVERHEAT_CONFIRM_TICKS   = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // Register reset values
  localparam logic [7:0] RST_ROOM_OVERHEAT_TEMP       = 8'd50;
  localparam logic [7:0] RST_ROOM_OVERHEAT_CLEAR_TEMP = 8'd45;
  localparam logic [7:0] RST_TANK_TRIP_TEMP           = 8'd98;
  localparam logic [7:0] RST_LOW_WATER_RECOVER_TICKS  = 8'd100;
  localparam logic [7:0] RST_OVERHEAT_CONFIRM_TICKS   = 8'd30;

  // Altitude codes
  localparam logic [1:0] ALT_HIGH  = 2'd0;
  localparam logic [1:0] ALT_MID   = 2'd1;
  localparam logic [1:0] ALT_LOW   = 2'd2;
  localparam logic [1:0] ALT_OTHER = 2'd3;

  // Thermostat temperatures
  localparam logic [7:0] OFF_HIGH      = 8'd93;
  localparam logic [7:0] OFF_MID       = 8'd90;
  localparam logic [7:0] OFF_LOW       = 8'd86;
  localparam logic [7:0] ON_NO_USE     = 8'd65;
  localparam logic [7:0] ON_SLEEP_HIGH = 8'd80;
  localparam logic [7:0] ON_SLEEP_MID  = 8'd77;
  localparam logic [7:0] ON_SLEEP_LOW  = 8'd75;
  localparam logic [7:0] ON_NORM_HIGH  = 8'd88;
  localparam logic [7:0] ON_NORM_MID   = 8'd85;
  localparam logic [7:0] ON_NORM_LOW   = 8'd81;

  // Inhibit mask bit positions
  localparam int INH_FIRST_FILL = 0;
  localparam int INH_DISABLED   = 1;
  localparam int INH_FAULT      = 2;
  localparam int INH_LOW_WATER  = 3;
  localparam int INH_OVERHEAT   = 4;
  localparam int INH_SAFETY     = 5;

  typedef struct packed {
    logic       control_enable;
    logic [1:0] altitude_mode;
    logic       no_use_saving;
    logic       sleep_mode;
    logic [7:0] hot_tank_temp;
    logic [7:0] room_temp;
    logic       room_sensor_fault;
    logic [6:0] fault_flags;
    logic       room_water_short;
    logic       first_fill_done;
    logic       hot_enabled;
    logic       compressor_stable;
  } thhc_in_t;

  typedef struct packed {
    logic       heater_on;
    logic       heating_demand;
    logic [5:0] inhibit_mask;
  } thhc_out_t;

  typedef struct packed {
    logic [7:0] room_overheat_temp;
    logic [7:0] room_overheat_clear_temp;
    logic [7:0] tank_trip_temp;
    logic [7:0] low_water_recover_ticks;
    logic [7:0] overheat_confirm_ticks;
  } thhc_cfg_t;

  typedef struct packed {
    logic       demand_flag;
    logic       low_water_latch;
    logic [7:0] recover_count;
    logic       overheat_latch;
    logic [7:0] overheat_count;
    logic       safety_latch;
    logic       drive_latch;
    logic [2:0] gate_bits;
  } thhc_state_t;

  function automatic logic [7:0] off_temp(input logic [1:0] alt);
    logic [7:0] t;
    case (alt)
      ALT_HIGH:  t = OFF_HIGH;
      ALT_MID:   t = OFF_MID;
      ALT_LOW:   t = OFF_LOW;
      ALT_OTHER: t = OFF_HIGH;
      default:   t = OFF_HIGH;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] on_temp(input logic [1:0] alt, input logic no_use,
                                         input logic sleep);
    logic [7:0] t;
    if (no_use) begin
      t = ON_NO_USE;
    end else if (sleep) begin
      case (alt)
        ALT_MID: t = ON_SLEEP_MID;
        ALT_LOW: t = ON_SLEEP_LOW;
        default: t = ON_SLEEP_HIGH;
      endcase
    end else begin
      case (alt)
        ALT_MID: t = ON_NORM_MID;
        ALT_LOW: t = ON_NORM_LOW;
        default: t = ON_NORM_HIGH;
      endcase
    end
    return t;
  endfunction

  function automatic logic [5:0] mask_of(input thhc_state_t s);
    logic [5:0] m;
    m = '0;
    m[INH_FIRST_FILL] = s.gate_bits[INH_FIRST_FILL];
    m[INH_DISABLED]   = s.gate_bits[INH_DISABLED];
    m[INH_FAULT]      = s.gate_bits[INH_FAULT];
    m[INH_LOW_WATER]  = s.low_water_latch;
    m[INH_OVERHEAT]   = s.overheat_latch;
    m[INH_SAFETY]     = s.safety_latch;
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/thhc_in_if.sv =====
`default_nettype none
interface thhc_in_if;
  import thhc_pkg::*;
  logic     valid;
  logic     ready;
  thhc_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/thhc_out_if.sv =====
`default_nettype none
interface thhc_out_if;
  import thhc_pkg::*;
  logic      valid;
  logic      ready;
  thhc_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/thhc_cfg.sv =====
`default_nettype none
module thhc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [thhc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [thhc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output thhc_pkg::thhc_cfg_t                  cfg
);
  import thhc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.room_overheat_temp       <= RST_ROOM_OVERHEAT_TEMP;
      cfg.room_overheat_clear_temp <= RST_ROOM_OVERHEAT_CLEAR_TEMP;
      cfg.tank_trip_temp           <= RST_TANK_TRIP_TEMP;
      cfg.low_water_recover_ticks  <= RST_LOW_WATER_RECOVER_TICKS;
      cfg.overheat_confirm_ticks   <= RST_OVERHEAT_CONFIRM_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROOM_OVERHEAT_TEMP:       cfg.room_overheat_temp       <= cfg_data;
        REG_ROOM_OVERHEAT_CLEAR_TEMP: cfg.room_overheat_clear_temp <= cfg_data;
        REG_TANK_TRIP_TEMP:           cfg.tank_trip_temp           <= cfg_data;
        REG_LOW_WATER_RECOVER_TICKS:  cfg.low_water_recover_ticks  <= cfg_data;
        REG_OVERHEAT_CONFIRM_TICKS:   cfg.overheat_confirm_ticks   <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/thhc_calc.sv =====
`default_nettype none
module thhc_calc (
  input  wire thhc_pkg::thhc_in_t    item,
  input  wire thhc_pkg::thhc_cfg_t   cfg,
  input  wire thhc_pkg::thhc_state_t st,
  output thhc_pkg::thhc_state_t      st_next,
  output thhc_pkg::thhc_out_t        res
);
  import thhc_pkg::*;

  logic [7:0] off_t;
  logic [7:0] on_t;
  logic [7:0] recover_inc;
  logic [7:0] overheat_inc;

  assign off_t        = off_temp(item.altitude_mode);
  assign on_t         = on_temp(item.altitude_mode, item.no_use_saving, item.sleep_mode);
  assign recover_inc  = st.recover_count + 8'd1;
  assign overheat_inc = st.overheat_count + 8'd1;

  always_comb begin
    st_next = st;
    if (item.control_enable) begin
      // Thermostat hysteresis
      if (item.hot_tank_temp >= off_t) begin
        st_next.demand_flag = 1'b0;
      end else if (item.hot_tank_temp <= on_t) begin
        st_next.demand_flag = 1'b1;
      end

      st_next.gate_bits[INH_FIRST_FILL] = ~item.first_fill_done;
      st_next.gate_bits[INH_DISABLED]   = ~item.hot_enabled;
      st_next.gate_bits[INH_FAULT]      = |item.fault_flags;

      // Low water latch with recovery delay
      if (item.room_water_short) begin
        st_next.recover_count   = '0;
        st_next.low_water_latch = 1'b1;
      end else if (st.low_water_latch) begin
        st_next.recover_count = recover_inc;
        if (recover_inc >= cfg.low_water_recover_ticks) begin
          st_next.recover_count   = '0;
          st_next.low_water_latch = 1'b0;
        end
      end else begin
        st_next.recover_count = '0;
      end

      // Room overheat confirm and clear
      if (item.room_sensor_fault) begin
        st_next.overheat_latch = 1'b0;
        st_next.overheat_count = '0;
      end else if (item.room_temp >= cfg.room_overheat_temp) begin
        st_next.overheat_count = overheat_inc;
        if (overheat_inc >= cfg.overheat_confirm_ticks) begin
          st_next.overheat_count = cfg.overheat_confirm_ticks;
          st_next.overheat_latch = 1'b1;
        end
      end else if (st.overheat_latch) begin
        if (item.room_temp <= cfg.room_overheat_clear_temp) begin
          st_next.overheat_latch = 1'b0;
        end
      end else begin
        st_next.overheat_count = '0;
      end

      st_next.safety_latch = (item.hot_tank_temp >= cfg.tank_trip_temp);

      // Heater drive: off on inhibit or no demand, hold while compressor settles
      if (mask_of(st_next) != '0) begin
        st_next.drive_latch = 1'b0;
      end else if (st_next.demand_flag) begin
        if (item.compressor_stable) begin
          st_next.drive_latch = 1'b1;
        end
      end else begin
        st_next.drive_latch = 1'b0;
      end
    end

    res.heater_on      = st_next.drive_latch;
    res.heating_demand = st_next.demand_flag;
    res.inhibit_mask   = mask_of(st_next);
  end
endmodule
`default_nettype wire

// ===== rtl/tank_heater_hysteresis_control_core.sv =====
`default_nettype none
// Tank heater hysteresis control core.
// An accepted transaction passes through the input stage register and then the
// result register, from which it shows on out_ch; a stall on out_ch holds it there.
// One transaction per cycle while out_ch is not stalled; the control state loop closes
// through the update logic between the input register and the result register.
// Reset (rst, synchronous, active high): empties both stages, clears all control
// state and loads the configuration registers with their default values.
module tank_heater_hysteresis_control_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  thhc_in_if.sink                               in_ch,
  thhc_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [thhc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [thhc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import thhc_pkg::*;

  thhc_cfg_t   cfg;
  thhc_state_t st;
  thhc_state_t st_next;
  thhc_out_t   res;

  // Input stage register
  logic        s1_valid;
  thhc_in_t    s1_item;

  // Result register
  logic        out_valid;
  thhc_out_t   out_res;

  logic        advance;
  logic        in_ready;

  // Advance whenever the result register is empty or being drained this cycle.
  assign advance  = ~out_valid | out_ch.ready;
  // Take a new transaction whenever the input stage is empty or moves forward.
  assign in_ready = ~s1_valid | advance;

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_res;

  thhc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // State update and result formation for the item in the input stage.
  thhc_calc u_calc (
    .item    (s1_item),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        // Commit state only when the item actually moves into the result register.
        if (s1_valid) begin
          st <= st_next;
        end
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_item <= in_ch.payload;
    end
    if (advance && s1_valid) begin
      out_res <= res;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/thhc_checker.sv =====
`default_nettype none
module thhc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       heater_on,
  input wire logic       heating_demand,
  input wire logic [5:0] inhibit_mask
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heater_on)
      && $stable(heating_demand) && $stable(inhibit_mask))
    else $error("result changed while stalled");

  // Heater drives only with demand.
  a_drive_needs_demand: assert property (@(posedge clk) disable iff (rst)
    out_valid && heater_on |-> heating_demand)
    else $error("heater on without demand");

  // Heater drives only with no inhibit.
  a_drive_no_inhibit: assert property (@(posedge clk) disable iff (rst)
    out_valid && heater_on |-> inhibit_mask == 6'd0)
    else $error("heater on while inhibited");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tank_heater_hysteresis_control_core thhc_checker u_thhc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .heater_on      (out_ch.payload.heater_on),
  .heating_demand (out_ch.payload.heating_demand),
  .inhibit_mask   (out_ch.payload.inhibit_mask)
);
`default_nettype wire
